[hdl/rvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_pkg: shared constants for the RV32 subset core
// Opcodes, funct codes, item op codes, status codes and the ALU function.
// ----------------------------------------------------------------------------
package rvc_pkg;

  localparam int unsigned DataWordsDefault = 256;

  localparam logic [6:0] OPC_ALU    = 7'd51;
  localparam logic [6:0] OPC_ALUI   = 7'd19;
  localparam logic [6:0] OPC_LUI    = 7'd55;
  localparam logic [6:0] OPC_AUIPC  = 7'd23;
  localparam logic [6:0] OPC_LOAD   = 7'd3;
  localparam logic [6:0] OPC_STORE  = 7'd35;
  localparam logic [6:0] OPC_JAL    = 7'd111;
  localparam logic [6:0] OPC_JALR   = 7'd103;
  localparam logic [6:0] OPC_BRANCH = 7'd99;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MUL  = 7'h01;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_WORD = 3'd2;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_RAN     = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // alt selects SUB for add and SRA for shift right
  function automatic logic [31:0] alu_f(input logic [2:0] f3, input logic alt,
                                        input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    case (f3)
      F3_ADD:  r = alt ? a - b : a + b;
      F3_SLL:  r = a << b[4:0];
      F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: r = {31'd0, a < b};
      F3_XOR:  r = a ^ b;
      F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

endpackage

[hdl/rvc_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_ifs: item channels of the RV32 subset core
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rvc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] instruction;
  logic [7:0]  mem_index;
  logic [31:0] mem_value;

  modport source(output valid, op, instruction, mem_index, mem_value, input ready);
  modport sink(input valid, op, instruction, mem_index, mem_value, output ready);
endinterface

interface rvc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] fetch_pc;
  logic [31:0] read_data;

  modport source(output valid, status, fetch_pc, read_data, input ready);
  modport sink(input valid, status, fetch_pc, read_data, output ready);
endinterface

[hdl/rv32im_subset_core_step.sv]
`timescale 1ns / 1ps
// The execute stage registers each input item and the result register holds its result;
//   LW and data readback first issue a registered data memory read.
// Throughput: one item per cycle while the result register is empty or taken, except
//   LW and readback, which hold the execute stage until their read data returns.
// Reset: PC cleared, register file reads zero (valid bits), output empty;
//   data memory content is undefined until written.
// ----------------------------------------------------------------------------
// rv32im_subset_core_step: RV32 subset core, one instruction per transaction
// Execute stage that registers the input item with the register-file read, then a result register.
// ----------------------------------------------------------------------------
module rv32im_subset_core_step #(
  parameter int unsigned DATA_WORDS = rvc_pkg::DataWordsDefault  // power of two
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rvc_in_if.sink     in_i,
  rvc_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(DATA_WORDS);

  // ---------------- execute stage registers ----------------
  logic        s1_valid_q;
  logic        s1_phase_q;      // read phase: data memory read issued, data available
  logic [1:0]  s1_op_q;
  logic [31:0] s1_instr_q;
  logic [7:0]  s1_index_q;
  logic [31:0] s1_value_q;

  logic [31:0] pc_q;

  // register file: two read copies, valid bits give the zero reset
  logic [31:0] rf_valid_q;
  logic [4:0]  byp_rd_q;        // last register written, for read-during-write
  logic [31:0] byp_data_q;
  logic        byp_vld_q;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_pc_q;
  logic [31:0] out_rdata_q;

  logic        accept, leave, done, needs_mem;
  logic        rf_we, dm_we, dm_re;
  logic [31:0] rf1_rdata, rf2_rdata, dm_rdata;
  logic [AW-1:0] dm_waddr, dm_raddr;
  logic [31:0] dm_wdata;

  // ---------------- instruction fields ----------------
  logic [31:0] w;
  logic [6:0]  opcode, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;

  assign w      = s1_instr_q;
  assign opcode = w[6:0];
  assign rd     = w[11:7];
  assign f3     = w[14:12];
  assign rs1    = w[19:15];
  assign rs2    = w[24:20];
  assign f7     = w[31:25];

  // operands: x0, then the latest write, then the RAM copy if ever written
  logic [31:0] a, b;
  always_comb begin
    if (rs1 == 5'd0) begin
      a = '0;
    end else if (byp_vld_q && byp_rd_q == rs1) begin
      a = byp_data_q;
    end else if (rf_valid_q[rs1]) begin
      a = rf1_rdata;
    end else begin
      a = '0;
    end
    if (rs2 == 5'd0) begin
      b = '0;
    end else if (byp_vld_q && byp_rd_q == rs2) begin
      b = byp_data_q;
    end else if (rf_valid_q[rs2]) begin
      b = rf2_rdata;
    end else begin
      b = '0;
    end
  end

  // ---------------- decode and execute ----------------
  logic [1:0]  status;
  logic        wr, is_load, is_store;
  logic [31:0] val, nxt, imm_i, imm_s, imm_j, imm_b, ea, prod;
  logic        take;

  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign prod  = a * b;

  always_comb begin
    status   = rvc_pkg::ST_RAN;
    wr       = 1'b0;
    is_load  = 1'b0;
    is_store = 1'b0;
    val      = '0;
    nxt      = pc_q + 32'd4;
    ea       = a + imm_i;
    take     = 1'b0;
    if (w == '0) begin
      status = rvc_pkg::ST_ZERO;
    end else begin
      case (opcode)
        rvc_pkg::OPC_ALU: begin
          wr = 1'b1;
          if (f7 == rvc_pkg::F7_BASE) begin
            val = rvc_pkg::alu_f(f3, 1'b0, a, b);
          end else if (f7 == rvc_pkg::F7_ALT &&
                       (f3 == rvc_pkg::F3_ADD || f3 == rvc_pkg::F3_SR)) begin
            val = rvc_pkg::alu_f(f3, 1'b1, a, b);
          end else if (f7 == rvc_pkg::F7_MUL && f3 == rvc_pkg::F3_ADD) begin
            val = prod;
          end else begin
            status = rvc_pkg::ST_INVALID;
          end
        end
        rvc_pkg::OPC_ALUI: begin
          wr = 1'b1;
          if (f3 == rvc_pkg::F3_SLL) begin
            if (f7 != rvc_pkg::F7_BASE) status = rvc_pkg::ST_INVALID;
            val = rvc_pkg::alu_f(f3, 1'b0, a, imm_i);
          end else if (f3 == rvc_pkg::F3_SR) begin
            if (f7 == rvc_pkg::F7_BASE) begin
              val = rvc_pkg::alu_f(f3, 1'b0, a, imm_i);
            end else if (f7 == rvc_pkg::F7_ALT) begin
              val = rvc_pkg::alu_f(f3, 1'b1, a, imm_i);
            end else begin
              status = rvc_pkg::ST_INVALID;
            end
          end else begin
            val = rvc_pkg::alu_f(f3, 1'b0, a, imm_i);
          end
        end
        rvc_pkg::OPC_LUI: begin
          wr  = 1'b1;
          val = {w[31:12], 12'd0};
        end
        rvc_pkg::OPC_AUIPC: begin
          wr  = 1'b1;
          val = pc_q + {w[31:12], 12'd0};
        end
        rvc_pkg::OPC_LOAD: begin
          if (f3 != rvc_pkg::F3_WORD) begin
            status = rvc_pkg::ST_INVALID;
          end else begin
            wr      = 1'b1;
            is_load = 1'b1;
            val     = dm_rdata;
          end
        end
        rvc_pkg::OPC_STORE: begin
          ea = a + imm_s;
          if (f3 != rvc_pkg::F3_WORD) begin
            status = rvc_pkg::ST_INVALID;
          end else begin
            is_store = 1'b1;
          end
        end
        rvc_pkg::OPC_JAL: begin
          wr  = 1'b1;
          val = pc_q + 32'd4;
          nxt = pc_q + imm_j;
        end
        rvc_pkg::OPC_JALR: begin
          if (f3 != rvc_pkg::F3_ADD) begin
            status = rvc_pkg::ST_INVALID;
          end else begin
            wr  = 1'b1;
            val = pc_q + 32'd4;
            nxt = {ea[31:1], 1'b0};
          end
        end
        rvc_pkg::OPC_BRANCH: begin
          case (f3)
            rvc_pkg::F3_BEQ:  take = (a == b);
            rvc_pkg::F3_BNE:  take = (a != b);
            rvc_pkg::F3_BLT:  take = $signed(a) < $signed(b);
            rvc_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
            rvc_pkg::F3_BLTU: take = (a < b);
            rvc_pkg::F3_BGEU: take = (a >= b);
            default:          status = rvc_pkg::ST_INVALID;
          endcase
          if (take) nxt = pc_q + imm_b;
        end
        default: status = rvc_pkg::ST_INVALID;
      endcase
    end
  end

  logic is_exec, exec_ok;
  assign is_exec = (s1_op_q == rvc_pkg::OP_EXEC);
  assign exec_ok = is_exec && (status == rvc_pkg::ST_RAN);

  // ---------------- stage control ----------------
  // LW and readback first issue the data memory read, then finish in the read phase
  assign needs_mem = (exec_ok && is_load) || (s1_op_q == rvc_pkg::OP_READ);
  assign done      = !needs_mem || s1_phase_q;
  assign leave     = s1_valid_q && done && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || leave;
  assign accept    = in_i.valid && in_i.ready;

  assign rf_we = leave && exec_ok && wr && (rd != 5'd0);

  // data memory: one write at leave, one read issued before the read phase
  assign dm_re    = s1_valid_q && needs_mem && !s1_phase_q;
  assign dm_we    = leave && ((s1_op_q == rvc_pkg::OP_WRITE) || (exec_ok && is_store));
  assign dm_raddr = (s1_op_q == rvc_pkg::OP_READ) ? AW'(s1_index_q) : ea[AW+1:2];
  assign dm_waddr = (s1_op_q == rvc_pkg::OP_WRITE) ? AW'(s1_index_q) : ea[AW+1:2];
  assign dm_wdata = (s1_op_q == rvc_pkg::OP_WRITE) ? s1_value_q : b;

  rvc_ram #(.Width(32), .Depth(32)) u_rf1 (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rd),
    .wdata_i (val),
    .re_i    (accept),
    .raddr_i (in_i.instruction[19:15]),
    .rdata_o (rf1_rdata)
  );

  rvc_ram #(.Width(32), .Depth(32)) u_rf2 (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rd),
    .wdata_i (val),
    .re_i    (accept),
    .raddr_i (in_i.instruction[24:20]),
    .rdata_o (rf2_rdata)
  );

  rvc_ram #(.Width(32), .Depth(DATA_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (dm_re),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_phase_q  <= 1'b0;
      pc_q        <= '0;
      rf_valid_q  <= '0;
      byp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (leave) begin
        s1_valid_q <= 1'b0;
      end
      if (leave) begin
        s1_phase_q <= 1'b0;
      end else if (dm_re) begin
        s1_phase_q <= 1'b1;
      end
      if (leave && exec_ok) begin
        pc_q <= nxt;
      end
      if (rf_we) begin
        rf_valid_q[rd] <= 1'b1;
        byp_vld_q      <= 1'b1;
      end
      if (leave) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= in_i.op;
      s1_instr_q <= in_i.instruction;
      s1_index_q <= in_i.mem_index;
      s1_value_q <= in_i.mem_value;
    end
    if (rf_we) begin
      byp_rd_q   <= rd;
      byp_data_q <= val;
    end
    if (leave) begin
      out_status_q <= is_exec ? status : rvc_pkg::ST_RAN;
      out_pc_q     <= exec_ok ? nxt : pc_q;
      out_rdata_q  <= (s1_op_q == rvc_pkg::OP_READ) ? dm_rdata : '0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.fetch_pc  = out_pc_q;
  assign out_o.read_data = out_rdata_q;

  // ---------------- assertions ----------------
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rd != 5'd0) else $error("write to x0");

  a_dm_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dm_re && dm_we)) else $error("data memory read and write together");

  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_phase_q |-> s1_valid_q && needs_mem) else $error("stray read phase");

  a_pc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !leave |=> $stable(pc_q)) else $error("PC moved without retire");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready) else $error("empty stage not ready");

endmodule

[hdl/rvc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvc_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rvc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
